>>> hdl/bffo_pkg.sv
// ----------------------------------------------------------------------------
// bffo_pkg
// Shared types, codes and defaults for the bounded frame FIFO with an
// overflow policy.
// ----------------------------------------------------------------------------
package bffo_pkg;

   // Default sizes handed to the top level.
   localparam int QUEUE_DEPTH_DEFAULT = 16;
   localparam int HANDLE_BITS_DEFAULT = 32;

   // Fixed field widths of the request and response.
   localparam int CMD_BITS      = 3;
   localparam int HANDLE_IO     = 32;
   localparam int STATUS_BITS   = 4;
   localparam int FILL_BITS     = 5;
   localparam int COUNT_BITS    = 32;
   localparam int RSP_DATA_BITS = 136;
   localparam int RSP_PAD_BITS  = RSP_DATA_BITS - HANDLE_IO - FILL_BITS - 3 * COUNT_BITS;

   // Configuration port.
   localparam int CSR_INDEX_BITS = 1;
   localparam int CSR_DATA_BITS  = 5;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_CAPACITY = 1'd0;
   localparam logic [CSR_INDEX_BITS-1:0] CSR_MODE     = 1'd1;
   localparam logic [FILL_BITS-1:0] CAPACITY_RESET = 5'd16;

   typedef enum logic [CMD_BITS-1:0] {
      CMD_PUSH   = 3'd0,
      CMD_POP    = 3'd1,
      CMD_CLEAR  = 3'd2,
      CMD_STOP   = 3'd3,
      CMD_RESUME = 3'd4,
      CMD_STATS  = 3'd5
   } cmd_type;

   typedef enum logic [1:0] {
      MODE_DROP_OLDEST = 2'd0,
      MODE_DROP_ALL    = 2'd1,
      MODE_DROP_NEWEST = 2'd2,
      MODE_BLOCK       = 2'd3
   } mode_type;

   typedef enum logic [STATUS_BITS-1:0] {
      ST_STORED   = 4'd0,
      ST_DROP_OLD = 4'd1,
      ST_DROP_ALL = 4'd2,
      ST_REJECT   = 4'd3,
      ST_RETRY    = 4'd4,
      ST_STOPPED  = 4'd5,
      ST_POPPED   = 4'd6,
      ST_EMPTY    = 4'd7,
      ST_DONE     = 4'd8
   } status_type;

endpackage

>>> hdl/bounded_frame_fifo_overflow_policy.sv
// A request accepted into the middle stage moves to the response register once that register frees up.
// Throughput: one request per cycle while the response channel does not stall; the queue
// memory is read once per pop and its registered output feeds the response stage directly.
// Reset: synchronous, active high; clears pointers, fill count, stop flag, totals,
// capacity (16) and mode (drop oldest). The handle memory is not cleared.
// ----------------------------------------------------------------------------
// bounded_frame_fifo_overflow_policy
// Bounded FIFO of frame handles with a run-time capacity, an overflow policy,
// stop and resume, and wrapping push, pop and drop totals.
// ----------------------------------------------------------------------------
module bounded_frame_fifo_overflow_policy #(
   parameter int QUEUE_DEPTH = bffo_pkg::QUEUE_DEPTH_DEFAULT,
   parameter int HANDLE_BITS = bffo_pkg::HANDLE_BITS_DEFAULT
) (
   input  logic                                clock,
   input  logic                                reset,
   // Request channel.
   input  logic                                req_tvalid,
   output logic                                req_tready,
   input  logic [bffo_pkg::HANDLE_IO-1:0]      req_tdata,   // frame_handle[31:0]
   input  logic [bffo_pkg::CMD_BITS-1:0]       req_tuser,   // cmd[2:0]
   // Response channel.
   output logic                                rsp_tvalid,
   input  logic                                rsp_tready,
   // frame_out[31:0], occupancy[36:32], pushed_total[68:37],
   // popped_total[100:69], dropped_total[132:101], zero pad[135:133]
   output logic [bffo_pkg::RSP_DATA_BITS-1:0]  rsp_tdata,
   output logic [bffo_pkg::STATUS_BITS-1:0]    rsp_tuser,   // status[3:0]
   // Configuration write channel.
   input  logic                                csr_valid,
   output logic                                csr_ready,
   input  logic [bffo_pkg::CSR_INDEX_BITS-1:0] csr_index,
   input  logic [bffo_pkg::CSR_DATA_BITS-1:0]  csr_data
);

   localparam int PTR_BITS = $clog2(QUEUE_DEPTH);
   localparam int FB = bffo_pkg::FILL_BITS;
   localparam int CB = bffo_pkg::COUNT_BITS;

   // Queue state.
   logic [HANDLE_BITS-1:0] mem [QUEUE_DEPTH];
   logic [PTR_BITS-1:0]    head_ff, head_in, tail_ff, tail_in;
   logic [FB-1:0]          fill_ff, fill_in;
   logic                   stopped_ff, stopped_in;
   logic [CB-1:0]          push_cnt_ff, push_cnt_in;
   logic [CB-1:0]          pop_cnt_ff, pop_cnt_in;
   logic [CB-1:0]          drop_cnt_ff, drop_cnt_in;
   logic [FB-1:0]          capacity_ff;
   bffo_pkg::mode_type     mode_ff;

   // Memory access controls.
   logic                   mem_we;
   logic [PTR_BITS-1:0]    mem_waddr;
   logic                   mem_re;
   logic [HANDLE_BITS-1:0] rd_data_ff;

   // Middle stage, waiting for the memory read.
   logic                   mid_valid_ff;
   bffo_pkg::status_type   mid_status_ff, status_in;
   logic [FB-1:0]          mid_fill_ff;
   logic [CB-1:0]          mid_push_ff, mid_pop_ff, mid_drop_ff;

   // Response register.
   logic                   rsp_valid_ff;
   bffo_pkg::status_type   rsp_status_ff;
   logic [bffo_pkg::HANDLE_IO-1:0] rsp_frame_ff;
   logic [FB-1:0]          rsp_fill_ff;
   logic [CB-1:0]          rsp_push_ff, rsp_pop_ff, rsp_drop_ff;

   logic                   out_free;
   logic                   mid_move;
   logic                   req_accept;
   logic [FB-1:0]          cap_eff;
   logic                   full;
   bffo_pkg::cmd_type      cmd;

   function automatic logic [PTR_BITS-1:0] next_ptr(input logic [PTR_BITS-1:0] p);
      logic [PTR_BITS-1:0] r;
      if (p == PTR_BITS'(QUEUE_DEPTH - 1)) begin
         r = '0;
      end else begin
         r = p + PTR_BITS'(1);
      end
      return r;
   endfunction

   // Handshake: the middle stage moves on when the response register frees up.
   assign out_free   = !rsp_valid_ff || rsp_tready;
   assign mid_move   = mid_valid_ff && out_free;
   assign req_tready = !mid_valid_ff || out_free;
   assign req_accept = req_tvalid && req_tready;
   assign csr_ready  = 1'b1;
   assign cmd        = bffo_pkg::cmd_type'(req_tuser);

   // Capacity clamped into the range the memory supports.
   always_comb begin
      if (capacity_ff == '0) begin
         cap_eff = FB'(1);
      end else if (32'(capacity_ff) > QUEUE_DEPTH) begin
         cap_eff = FB'(QUEUE_DEPTH);
      end else begin
         cap_eff = capacity_ff;
      end
   end
   assign full = fill_ff >= cap_eff;

   // Command decode and next queue state.
   always_comb begin
      head_in     = head_ff;
      tail_in     = tail_ff;
      fill_in     = fill_ff;
      stopped_in  = stopped_ff;
      push_cnt_in = push_cnt_ff;
      pop_cnt_in  = pop_cnt_ff;
      drop_cnt_in = drop_cnt_ff;
      status_in   = bffo_pkg::ST_DONE;
      mem_we      = 1'b0;
      mem_waddr   = tail_ff;
      mem_re      = 1'b0;
      unique case (cmd)
         bffo_pkg::CMD_PUSH: begin
            if (stopped_ff) begin
               status_in = bffo_pkg::ST_STOPPED;
            end else if (!full) begin
               push_cnt_in = push_cnt_ff + CB'(1);
               mem_we      = 1'b1;
               tail_in     = next_ptr(tail_ff);
               fill_in     = fill_ff + FB'(1);
               status_in   = bffo_pkg::ST_STORED;
            end else begin
               unique case (mode_ff)
                  bffo_pkg::MODE_DROP_OLDEST: begin
                     // Oldest handle leaves, the new one takes the tail.
                     push_cnt_in = push_cnt_ff + CB'(1);
                     drop_cnt_in = drop_cnt_ff + CB'(1);
                     head_in     = next_ptr(head_ff);
                     mem_we      = 1'b1;
                     tail_in     = next_ptr(tail_ff);
                     status_in   = bffo_pkg::ST_DROP_OLD;
                  end
                  bffo_pkg::MODE_DROP_ALL: begin
                     // Queue restarts at entry zero holding only the new handle.
                     push_cnt_in = push_cnt_ff + CB'(1);
                     drop_cnt_in = drop_cnt_ff + CB'(fill_ff);
                     head_in     = '0;
                     mem_we      = 1'b1;
                     mem_waddr   = '0;
                     tail_in     = next_ptr('0);
                     fill_in     = FB'(1);
                     status_in   = bffo_pkg::ST_DROP_ALL;
                  end
                  bffo_pkg::MODE_DROP_NEWEST: begin
                     push_cnt_in = push_cnt_ff + CB'(1);
                     drop_cnt_in = drop_cnt_ff + CB'(1);
                     status_in   = bffo_pkg::ST_REJECT;
                  end
                  bffo_pkg::MODE_BLOCK: begin
                     status_in = bffo_pkg::ST_RETRY;
                  end
                  default: begin
                     status_in = bffo_pkg::ST_RETRY;
                  end
               endcase
            end
         end
         bffo_pkg::CMD_POP: begin
            if (fill_ff == '0) begin
               status_in = bffo_pkg::ST_EMPTY;
            end else begin
               mem_re     = 1'b1;
               head_in    = next_ptr(head_ff);
               fill_in    = fill_ff - FB'(1);
               pop_cnt_in = pop_cnt_ff + CB'(1);
               status_in  = bffo_pkg::ST_POPPED;
            end
         end
         bffo_pkg::CMD_CLEAR: begin
            fill_in = '0;
            head_in = '0;
            tail_in = '0;
         end
         bffo_pkg::CMD_STOP: begin
            stopped_in = 1'b1;
         end
         bffo_pkg::CMD_RESUME: begin
            stopped_in = 1'b0;
         end
         bffo_pkg::CMD_STATS: begin
            push_cnt_in = '0;
            pop_cnt_in  = '0;
            drop_cnt_in = '0;
         end
         default: begin
            status_in = bffo_pkg::ST_DONE;
         end
      endcase
   end

   // Handle memory with a registered read port.
   always_ff @(posedge clock) begin
      if (req_accept && mem_we) begin
         mem[mem_waddr] <= HANDLE_BITS'(req_tdata);
      end
      if (req_accept && mem_re) begin
         rd_data_ff <= mem[head_ff];
      end
   end

   // Queue control state and configuration.
   always_ff @(posedge clock) begin
      if (reset) begin
         head_ff     <= '0;
         tail_ff     <= '0;
         fill_ff     <= '0;
         stopped_ff  <= 1'b0;
         push_cnt_ff <= '0;
         pop_cnt_ff  <= '0;
         drop_cnt_ff <= '0;
         capacity_ff <= bffo_pkg::CAPACITY_RESET;
         mode_ff     <= bffo_pkg::MODE_DROP_OLDEST;
      end else begin
         if (req_accept) begin
            head_ff     <= head_in;
            tail_ff     <= tail_in;
            fill_ff     <= fill_in;
            stopped_ff  <= stopped_in;
            push_cnt_ff <= push_cnt_in;
            pop_cnt_ff  <= pop_cnt_in;
            drop_cnt_ff <= drop_cnt_in;
         end
         if (csr_valid && csr_ready) begin
            if (csr_index == bffo_pkg::CSR_CAPACITY) begin
               capacity_ff <= csr_data;
            end else if (csr_index == bffo_pkg::CSR_MODE) begin
               mode_ff <= bffo_pkg::mode_type'(csr_data[1:0]);
            end
         end
      end
   end

   // Valid bits of the middle stage and the response register.
   always_ff @(posedge clock) begin
      if (reset) begin
         mid_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (req_accept) begin
            mid_valid_ff <= 1'b1;
         end else if (mid_move) begin
            mid_valid_ff <= 1'b0;
         end
         if (mid_move) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_tready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // Payload of the middle stage and the response register.
   always_ff @(posedge clock) begin
      if (req_accept) begin
         mid_status_ff <= status_in;
         mid_fill_ff   <= fill_in;
         mid_push_ff   <= push_cnt_in;
         mid_pop_ff    <= pop_cnt_in;
         mid_drop_ff   <= drop_cnt_in;
      end
      if (mid_move) begin
         rsp_status_ff <= mid_status_ff;
         rsp_frame_ff  <= (mid_status_ff == bffo_pkg::ST_POPPED) ?
                          bffo_pkg::HANDLE_IO'(rd_data_ff) : '0;
         rsp_fill_ff   <= mid_fill_ff;
         rsp_push_ff   <= mid_push_ff;
         rsp_pop_ff    <= mid_pop_ff;
         rsp_drop_ff   <= mid_drop_ff;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tuser  = rsp_status_ff;
   assign rsp_tdata  = {{bffo_pkg::RSP_PAD_BITS{1'b0}}, rsp_drop_ff, rsp_pop_ff,
                        rsp_push_ff, rsp_fill_ff, rsp_frame_ff};

`ifndef ASSERT_OFF
   // The fill count never passes the memory depth.
   a_fill_bound: assert property (@(posedge clock) disable iff (reset)
      32'(fill_ff) <= QUEUE_DEPTH)
      else $error("fill count exceeds queue depth");

   // A pop from a non-empty queue lowers the fill count by one.
   a_pop_fill: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd == bffo_pkg::CMD_POP && fill_ff != '0)
      |=> fill_ff == $past(fill_ff) - FB'(1))
      else $error("pop did not lower fill count");

   // A push into free room advances the push total by one.
   a_push_count: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd == bffo_pkg::CMD_PUSH && !stopped_ff && !full)
      |=> push_cnt_ff == $past(push_cnt_ff) + CB'(1))
      else $error("stored push not counted");

   // A push while stopped leaves the queue alone.
   a_stopped_push: assert property (@(posedge clock) disable iff (reset)
      (req_accept && cmd == bffo_pkg::CMD_PUSH && stopped_ff)
      |=> $stable(fill_ff) && $stable(tail_ff) && $stable(push_cnt_ff))
      else $error("push while stopped changed the queue");
`endif

endmodule
